/* rtl/slip_crc16_frame_decoder_assert.svh */
// ---------------------------------------------------------------------------
// SLIP CRC-16 frame decoder assertion macros
// Shared property forms for the decoder; clocked on clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef SLIP_CRC16_FRAME_DECODER_ASSERT_SVH
`define SLIP_CRC16_FRAME_DECODER_ASSERT_SVH

// same-cycle implication
`define SCD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/scd_pkg.sv */
// ---------------------------------------------------------------------------
// SLIP CRC-16 frame decoder package
// Shared constants, status codes, result word type and CRC byte update.
// ---------------------------------------------------------------------------
package scd_pkg;

  localparam int unsigned MAX_FRAME_DEF = 256;

  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;

  localparam logic [15:0] CRC_POLY = 16'h8005;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  localparam int unsigned HEADER_LEN = 7;
  localparam int unsigned EMIT_AT    = HEADER_LEN + 2;
  localparam int unsigned UNESC_W    = $clog2(EMIT_AT + 1);

  localparam int unsigned CNT_W     = 9;
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [CNT_W-1:0] LIMIT_RST = 9'd256;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_CRC      = 3'd1,
    ST_TOO_SHORT    = 3'd2,
    ST_TOO_LONG     = 3'd3,
    ST_DANGLING_ESC = 3'd4
  } status_t;

  typedef struct packed {
    logic       valid;
    logic       is_status;
    logic [7:0] payload;
    status_t    status;
  } scd_result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/scd_in_stage.sv */
// ---------------------------------------------------------------------------
// SLIP CRC-16 frame decoder input stage
// Registers one received word; releases it when the core advances.
// ---------------------------------------------------------------------------
module scd_in_stage
  import scd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       advance,
  output logic       s1_valid,
  output logic [7:0] s1_byte
);

  logic       valid_r;
  logic [7:0] byte_r;

  assign in_tready = !valid_r || advance;
  assign s1_valid  = valid_r;
  assign s1_byte   = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata;
    end
  end

endmodule

/* rtl/scd_core.sv */
// ---------------------------------------------------------------------------
// SLIP CRC-16 frame decoder core
// Frame state, unescape, CRC update, header drop, delay line and status.
// ---------------------------------------------------------------------------
`include "slip_crc16_frame_decoder_assert.svh"

module scd_core
  import scd_pkg::*;
#(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  output scd_result_t      res
);

  localparam logic [CNT_W-1:0] LIMIT_CAP = CNT_W'(MAX_FRAME);
  localparam logic [UNESC_W-1:0] EMIT_CNT = UNESC_W'(EMIT_AT);

  logic [CNT_W-1:0]   max_len_r;
  logic               in_frame_r, in_frame_nxt;
  logic               esc_r, esc_nxt;
  logic [15:0]        crc_r, crc_nxt;
  logic [UNESC_W-1:0] unesc_r, unesc_nxt;
  logic [CNT_W-1:0]   raw_r, raw_nxt;
  logic               too_long_r, too_long_nxt;
  logic [7:0]         dly0_r, dly0_nxt;
  logic [7:0]         dly1_r, dly1_nxt;

  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] raw_inc;
  logic             have_u;
  logic [7:0]       u;
  status_t          status;

  assign limit   = (max_len_r < LIMIT_CAP) ? max_len_r : LIMIT_CAP;
  assign raw_inc = (raw_r == CNT_MAX) ? raw_r : raw_r + CNT_W'(1);

  always_comb begin
    priority if (too_long_r || raw_r >= limit) begin
      status = ST_TOO_LONG;
    end else if (esc_r) begin
      status = ST_DANGLING_ESC;
    end else if (unesc_r < EMIT_CNT) begin
      status = ST_TOO_SHORT;
    end else if (crc_r != 16'h0000) begin
      status = ST_BAD_CRC;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    have_u = 1'b0;
    u      = rx_byte;
    if (esc_r) begin
      have_u = 1'b1;
      u      = (rx_byte == SLIP_ESC_END) ? SLIP_END : SLIP_ESC;
    end else if (rx_byte != SLIP_ESC) begin
      have_u = 1'b1;
    end
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    crc_nxt      = crc_r;
    unesc_nxt    = unesc_r;
    raw_nxt      = raw_r;
    too_long_nxt = too_long_r;
    dly0_nxt     = dly0_r;
    dly1_nxt     = dly1_r;
    res          = '0;
    if (step) begin
      if (!in_frame_r) begin
        if (rx_byte == SLIP_END) begin
          in_frame_nxt = 1'b1;
          esc_nxt      = 1'b0;
          crc_nxt      = 16'h0000;
          unesc_nxt    = '0;
          raw_nxt      = CNT_W'(1);
          too_long_nxt = 1'b0;
        end
      end else if (rx_byte == SLIP_END) begin
        if (raw_r > CNT_W'(1) || esc_r) begin
          res.valid     = 1'b1;
          res.is_status = 1'b1;
          res.status    = status;
          in_frame_nxt  = 1'b0;
          esc_nxt       = 1'b0;
        end
      end else begin
        raw_nxt = raw_inc;
        if (raw_inc >= limit) begin
          too_long_nxt = 1'b1;
        end
        esc_nxt = !esc_r && (rx_byte == SLIP_ESC);
        if (have_u) begin
          crc_nxt = crc_byte(crc_r, u);
          if (unesc_r == EMIT_CNT) begin
            res.valid   = 1'b1;
            res.payload = dly1_r;
          end else begin
            unesc_nxt = unesc_r + UNESC_W'(1);
          end
          dly1_nxt = dly0_r;
          dly0_nxt = u;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r  <= LIMIT_RST;
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
      crc_r      <= 16'h0000;
      unesc_r    <= '0;
      raw_r      <= '0;
      too_long_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
      crc_r      <= crc_nxt;
      unesc_r    <= unesc_nxt;
      raw_r      <= raw_nxt;
      too_long_r <= too_long_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dly0_r <= dly0_nxt;
    dly1_r <= dly1_nxt;
  end

  `SCD_ASSERT_SAME(a_payload_after_header, res.valid && !res.is_status,
    unesc_r == EMIT_CNT, "payload word before header and delay filled")
  `SCD_ASSERT_NEXT(a_hunt_after_status, res.valid && res.is_status,
    !in_frame_r && !esc_r, "status word did not return to hunting")
  `SCD_ASSERT_SAME(a_esc_in_frame, esc_r, in_frame_r, "escape pending outside a frame")
  `SCD_ASSERT_SAME(a_raw_nonzero, in_frame_r, raw_r != '0, "open frame with zero raw count")

endmodule

/* rtl/scd_out_stage.sv */
// ---------------------------------------------------------------------------
// SLIP CRC-16 frame decoder output stage
// Result register toward the master-side stream; sets the advance condition.
// ---------------------------------------------------------------------------
module scd_out_stage
  import scd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  scd_result_t res,
  output logic        advance,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic        out_tuser
);

  logic        valid_r;
  logic        is_status_r;
  logic [7:0]  payload_r;
  status_t     status_r;

  assign advance    = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {5'b00000, status_r, payload_r};
  assign out_tuser  = is_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      is_status_r <= res.is_status;
      payload_r   <= res.payload;
      status_r    <= res.status;
    end
  end

endmodule

/* rtl/slip_crc16_frame_decoder.sv */
// ---------------------------------------------------------------------------
// SLIP CRC-16 frame decoder
// Deframes SLIP line bytes, checks CRC-16/BUYPASS, emits payload and status.
// ---------------------------------------------------------------------------
// One line byte per in_ word, one word per clock sustained: each byte passes
// an input register, the combinational unescape/CRC/count logic and a result
// register; out_tready stalls flow back to in_tready. Bytes before the first
// 0xC0 are dropped. After the 7 header bytes, payload words (out_tuser 0)
// leave two bytes late so the CRC bytes never appear; the closing 0xC0 of
// a non-empty frame gives one status word (out_tuser 1):
// 0 ok, 1 bad CRC, 2 short, 3 too long, 4 dangling escape. Discard the
// frame's payload unless its status is ok. Write cfg_wr_data only while idle.
module slip_crc16_frame_decoder
  import scd_pkg::*;
#(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,     // [7:0] rx_byte
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [15:0]      out_tdata,    // [7:0] payload_byte, [10:8] frame_status
  output logic             out_tuser,    // [0] is_status
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data   // max_frame_length
);

  logic        advance;
  logic        s1_valid;
  logic [7:0]  s1_byte;
  scd_result_t res;

  scd_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .advance   (advance),
    .s1_valid  (s1_valid),
    .s1_byte   (s1_byte)
  );

  scd_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (s1_valid && advance),
    .rx_byte     (s1_byte),
    .res         (res)
  );

  scd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
